// ===== src/i2csr_pkg.sv =====
// Package: shared types and constants for the I2C target receiver.
package i2csr_pkg;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Register indexes on the configuration port
    localparam logic REG_READ_ADDR  = 1'b0;
    localparam logic REG_WRITE_ADDR = 1'b1;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_RX_ADDR  = 6'b000010,
        PH_ACK_ADDR = 6'b000100,
        PH_RX_BYTE  = 6'b001000,
        PH_ACK_BYTE = 6'b010000,
        PH_NACK     = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [7:0] read_address_byte;
        logic [7:0] write_address_byte;
    } cfg_t;

    typedef struct packed {
        logic       pull_data_low;
        logic       write_strobe;
        logic [7:0] byte_out;
        logic [7:0] byte_number;
        logic       read_requested;
    } result_t;

endpackage

// ===== src/i2csr_regs.sv =====
// Configuration registers: read and write address bytes behind an APB-style port.
module i2csr_regs
    import i2csr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [7:0] read_addr_reg;
    logic [7:0] write_addr_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_addr_reg  <= 8'd0;
            write_addr_reg <= 8'd0;
        end else if (wr_en) begin
            case (paddr[2])
                REG_READ_ADDR:  read_addr_reg  <= pwdata[7:0];
                REG_WRITE_ADDR: write_addr_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_READ_ADDR:  prdata = {24'd0, read_addr_reg};
            REG_WRITE_ADDR: prdata = {24'd0, write_addr_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg.read_address_byte  = read_addr_reg;
    assign cfg.write_address_byte = write_addr_reg;

endmodule

// ===== src/i2csr_core.sv =====
// Receiver state machine: one line sample per step, result is the state after the step.
module i2csr_core
    import i2csr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  logic    scl,
    input  logic    sda,
    input  cfg_t    cfg,
    output result_t result
);

    phase_t     phase_reg,    phase_next;
    logic [7:0] shift_reg,    shift_next;
    logic [3:0] bits_reg,     bits_next;
    logic       cwl_reg,      cwl_next;
    logic [7:0] count_reg,    count_next;
    logic       dir_read_reg, dir_read_next;
    logic [7:0] held_reg,     held_next;
    logic       drive_reg,    drive_next;
    logic       strobe_reg,   strobe_next;

    always_comb begin
        phase_next    = phase_reg;
        shift_next    = shift_reg;
        bits_next     = bits_reg;
        cwl_next      = cwl_reg;
        count_next    = count_reg;
        dir_read_next = dir_read_reg;
        held_next     = held_reg;
        drive_next    = drive_reg;
        strobe_next   = strobe_reg;
        case (phase_reg)
            PH_IDLE: begin
                strobe_next = 1'b0;
                if (scl && !sda) begin
                    phase_next = PH_RX_ADDR;
                    cwl_next   = 1'b0;
                    bits_next  = 4'd0;
                end
            end
            PH_RX_ADDR: begin
                if (bits_reg < BITS_PER_BYTE) begin
                    if (!scl) begin
                        drive_next = 1'b0;
                        cwl_next   = 1'b1;
                    end else if (cwl_reg) begin
                        cwl_next   = 1'b0;
                        bits_next  = bits_reg + 4'd1;
                        shift_next = {shift_reg[6:0], sda};
                    end
                end else begin
                    if (shift_reg == cfg.read_address_byte) begin
                        dir_read_next = 1'b1;
                        phase_next    = PH_ACK_ADDR;
                    end else if (shift_reg == cfg.write_address_byte) begin
                        dir_read_next = 1'b0;
                        phase_next    = PH_ACK_ADDR;
                    end else begin
                        phase_next    = PH_NACK;
                    end
                    cwl_next  = 1'b0;
                    bits_next = 4'd0;
                end
            end
            PH_ACK_ADDR: begin
                held_next = shift_reg;
                if (!cwl_reg) begin
                    if (!scl) begin
                        drive_next = 1'b1;
                    end
                    cwl_next = 1'b1;
                end else begin
                    cwl_next   = 1'b0;
                    phase_next = PH_RX_BYTE;
                end
            end
            PH_RX_BYTE: begin
                strobe_next = 1'b0;
                if (bits_reg < BITS_PER_BYTE) begin
                    if (!scl) begin
                        drive_next = 1'b0;
                        cwl_next   = 1'b1;
                    end else if (cwl_reg) begin
                        cwl_next   = 1'b0;
                        bits_next  = bits_reg + 4'd1;
                        shift_next = {shift_reg[6:0], sda};
                    end else if (!shift_reg[0] && sda) begin
                        // stop
                        bits_next  = 4'd0;
                        count_next = 8'd0;
                        drive_next = 1'b0;
                        phase_next = PH_IDLE;
                    end
                end else begin
                    if (!scl) begin
                        drive_next = 1'b1;
                    end
                    bits_next  = 4'd0;
                    count_next = count_reg + 8'd1;
                    phase_next = PH_ACK_BYTE;
                end
            end
            PH_ACK_BYTE: begin
                held_next   = shift_reg;
                strobe_next = 1'b1;
                if (scl) begin
                    cwl_next   = 1'b0;
                    phase_next = PH_RX_BYTE;
                end
            end
            PH_NACK: begin
                drive_next = 1'b0;
                if (scl && !cwl_reg && !shift_reg[0] && sda) begin
                    bits_next  = 4'd0;
                    count_next = 8'd0;
                    phase_next = PH_IDLE;
                end else begin
                    cwl_next   = !scl;
                    shift_next = {shift_reg[7:1], sda};
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            shift_reg    <= 8'd0;
            bits_reg     <= 4'd0;
            cwl_reg      <= 1'b0;
            count_reg    <= 8'd0;
            dir_read_reg <= 1'b0;
            held_reg     <= 8'd0;
            drive_reg    <= 1'b0;
            strobe_reg   <= 1'b0;
        end else if (step) begin
            phase_reg    <= phase_next;
            shift_reg    <= shift_next;
            bits_reg     <= bits_next;
            cwl_reg      <= cwl_next;
            count_reg    <= count_next;
            dir_read_reg <= dir_read_next;
            held_reg     <= held_next;
            drive_reg    <= drive_next;
            strobe_reg   <= strobe_next;
        end
    end

    assign result.pull_data_low  = drive_next;
    assign result.write_strobe   = strobe_next;
    assign result.byte_out       = held_next;
    assign result.byte_number    = count_next;
    assign result.read_requested = dir_read_next;

    a_strobe_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        strobe_reg |-> (phase_reg == PH_ACK_BYTE || phase_reg == PH_RX_BYTE))
        else $error("write strobe outside byte phases");

    a_bits_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_reg <= BITS_PER_BYTE)
        else $error("bit count beyond a byte");

    a_nack_released: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && phase_reg == PH_NACK) |=> !drive_reg)
        else $error("SDA driven after address mismatch");

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && phase_reg == PH_IDLE && !(scl && !sda)) |=> phase_reg == PH_IDLE)
        else $error("left idle without start");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(phase_reg) && $stable(count_reg))
        else $error("state moved without a sample");

endmodule

// ===== src/i2c_slave_receiver.sv =====
// Top level: I2C target receiver with sample input register and result register.
// Takes one SCL/SDA sample per clock and returns one result per sample: SDA drive,
// write strobe, last byte, byte index and direction, as they stand after that sample.
// A sample is accepted in every cycle while results are taken; an accepted sample sits in
// the input register until the result register is free, and the state machine's next state
// is then captured into the result register.
module i2c_slave_receiver
    import i2csr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_clock_line_high,
    input  logic        s_data_line_high,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_pull_data_low,
    output logic        m_write_strobe,
    output logic [7:0]  m_byte_out,
    output logic [7:0]  m_byte_number,
    output logic        m_read_requested,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic    in_valid_reg;
    logic    scl_reg;
    logic    sda_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t core_result;
    cfg_t    cfg;
    logic    step;

    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    i2csr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    i2csr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .scl     (scl_reg),
        .sda     (sda_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (step) begin
                in_valid_reg <= 1'b0;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            scl_reg <= s_clock_line_high;
            sda_reg <= s_data_line_high;
        end
        if (step) begin
            out_reg <= core_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_pull_data_low  = out_reg.pull_data_low;
    assign m_write_strobe   = out_reg.write_strobe;
    assign m_byte_out       = out_reg.byte_out;
    assign m_byte_number    = out_reg.byte_number;
    assign m_read_requested = out_reg.read_requested;

endmodule
